### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define RPE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define RPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/core/rpe_pkg.sv
// Types, codes and constants of the RSA private exponent block
package rpe_pkg;

    localparam int PRIME_BITS_DEF = 16;
    localparam int IN_W           = 16;
    localparam int DATA_W         = 32;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_P_NOT_PRIME = 2'd1,
        ST_Q_NOT_PRIME = 2'd2,
        ST_NOT_COPRIME = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_TEST_P,
        OP_TEST_Q,
        OP_DIV_TRIAL,
        OP_TRIAL_NEXT,
        OP_GCD1_INIT,
        OP_DIV_EUC,
        OP_EUC_STEP,
        OP_DIV_LAM,
        OP_LAM_MUL,
        OP_GCD2_INIT,
        OP_INV_INIT,
        OP_DIV_RED,
        OP_RED_DONE,
        OP_FIN1,
        OP_FIN2,
        OP_SET_STATUS,
        OP_PUBLISH
    } t_op;

    typedef struct packed {
        t_op     op;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic rem_zero;
        logic x_lt2;
        logic x_two;
        logic x_even;
        logic sq_gt_x;
        logic r1_zero;
        logic r0_one;
        logic lam_gt_one;
    } t_dstat;

    typedef enum logic [4:0] {
        S_IDLE,
        S_TP_INIT,
        S_T_CHK,
        S_T_WAIT,
        S_G1_INIT,
        S_EUC_CHK,
        S_EUC_WAIT,
        S_LAM_DIV,
        S_LAM_WAIT,
        S_G2_INIT,
        S_INV_INIT,
        S_RED,
        S_RED_WAIT,
        S_FIN1,
        S_FIN2,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        PH_G1,
        PH_G2,
        PH_INV
    } t_phase;

endpackage

### rtl/core/rpe_divider.sv
// Restoring divider, one quotient bit per cycle, with quotient-times-addend accumulation
`include "assert_macros.svh"

module rpe_divider #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    input  logic [W-1:0] i_addend,
    output logic         o_done,
    output logic [W-1:0] o_quot,
    output logic [W-1:0] o_rem,
    output logic [W-1:0] o_acc
);

    localparam int CNT_W = $clog2(W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem, r_quo, r_acc, r_dsr, r_add;
    logic [W:0]       w_shift, w_diff;
    logic             w_ge;

    assign w_shift = {r_rem, r_quo[W-1]};
    assign w_diff  = w_shift - {1'b0, r_dsr};
    assign w_ge    = !w_diff[W];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
        end else if (r_busy && (r_cnt == '0)) begin
            n_busy = 1'b0;
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CNT_W'(W - 1);
            r_rem <= '0;
            r_quo <= i_dividend;
            r_acc <= '0;
            r_dsr <= i_divisor;
            r_add <= i_addend;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            r_rem <= w_ge ? w_diff[W-1:0] : w_shift[W-1:0];
            r_quo <= {r_quo[W-2:0], w_ge};
            r_acc <= {r_acc[W-2:0], 1'b0} + (w_ge ? r_add : '0);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;
    assign o_acc  = r_acc;

    `RPE_ASSERT_IMP(a_start_when_idle, i_clk, i_rst_n, i_start, !r_busy)
    `RPE_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, r_done, !r_done && !r_busy)

endmodule

### rtl/core/rpe_datapath.sv
// Datapath: operand registers, multiplier, divider and result registers
module rpe_datapath #(
    parameter int PRIME_BITS = rpe_pkg::PRIME_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rpe_pkg::t_cmd              i_cmd,
    input  logic [rpe_pkg::IN_W-1:0]   i_prime_p,
    input  logic [rpe_pkg::IN_W-1:0]   i_prime_q,
    input  logic [rpe_pkg::DATA_W-1:0] i_public_exponent,
    output rpe_pkg::t_dstat            o_stat,
    output logic [rpe_pkg::DATA_W-1:0] o_private_exponent,
    output logic [rpe_pkg::DATA_W-1:0] o_modulus,
    output rpe_pkg::t_status           o_status
);

    import rpe_pkg::*;

    localparam int PB   = PRIME_BITS;
    localparam int LW   = 2 * PB;
    localparam int W    = (LW > DATA_W) ? LW : DATA_W;
    localparam int SQ_W = PB + 2;

    logic [PB-1:0]     r_p, r_q, r_x, r_dv;
    logic [SQ_W-1:0]   r_sq;
    logic [DATA_W-1:0] r_e, r_n, r_d;
    logic [W-1:0]      r_r0, r_r1, r_m0, r_m1, r_lam, r_mag;
    logic              r_idx;
    t_status           r_status;
    logic [DATA_W-1:0] r_o_d, r_o_n;
    t_status           r_o_st;

    logic [PB-1:0]     w_pm, w_qm, w_a, w_b, w_ma, w_mb;
    logic [LW-1:0]     w_prod;
    logic              w_start, w_done;
    logic [W-1:0]      w_dvd, w_dsr, w_add, w_quo, w_rem, w_acc, w_dfull;

    assign w_pm = PB'(i_prime_p);
    assign w_qm = PB'(i_prime_q);
    assign w_a  = r_p - PB'(1);
    assign w_b  = r_q - PB'(1);

    assign w_ma   = (i_cmd.op == OP_LOAD) ? w_pm : w_quo[PB-1:0];
    assign w_mb   = (i_cmd.op == OP_LOAD) ? w_qm : w_b;
    assign w_prod = LW'(w_ma) * LW'(w_mb);

    always_comb begin
        w_start = 1'b0;
        w_dvd   = r_r0;
        w_dsr   = r_r1;
        w_add   = '0;
        unique case (i_cmd.op)
            OP_DIV_TRIAL: begin
                w_start = 1'b1;
                w_dvd   = W'(r_x);
                w_dsr   = W'(r_dv);
            end
            OP_DIV_EUC: begin
                w_start = 1'b1;
                w_add   = r_m1;
            end
            OP_DIV_LAM: begin
                w_start = 1'b1;
                w_dvd   = W'(w_a);
                w_dsr   = r_r0;
            end
            OP_DIV_RED: begin
                w_start = 1'b1;
                w_dvd   = r_r1;
                w_dsr   = r_r0;
            end
            default: begin
            end
        endcase
    end

    rpe_divider #(
        .W (W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dsr),
        .i_addend   (w_add),
        .o_done     (w_done),
        .o_quot     (w_quo),
        .o_rem      (w_rem),
        .o_acc      (w_acc)
    );

    assign w_dfull = r_idx ? r_mag : ((r_mag == '0) ? '0 : (r_lam - r_mag));

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_p <= w_pm;
                r_q <= w_qm;
                r_e <= i_public_exponent;
                r_n <= DATA_W'(w_prod);
            end
            OP_TEST_P: begin
                r_x  <= r_p;
                r_dv <= PB'(3);
                r_sq <= SQ_W'(9);
            end
            OP_TEST_Q: begin
                r_x  <= r_q;
                r_dv <= PB'(3);
                r_sq <= SQ_W'(9);
            end
            OP_TRIAL_NEXT: begin
                r_dv <= r_dv + PB'(2);
                r_sq <= r_sq + {r_dv, 2'b00} + SQ_W'(4);
            end
            OP_GCD1_INIT: begin
                r_r0 <= W'(w_a);
                r_r1 <= W'(w_b);
            end
            OP_EUC_STEP: begin
                r_r0  <= r_r1;
                r_r1  <= w_rem;
                r_m0  <= r_m1;
                r_m1  <= r_m0 + w_acc;
                r_idx <= ~r_idx;
            end
            OP_LAM_MUL: begin
                r_lam <= W'(w_prod);
            end
            OP_GCD2_INIT: begin
                r_r0 <= W'(r_e);
                r_r1 <= r_lam;
            end
            OP_INV_INIT: begin
                r_r0  <= r_lam;
                r_r1  <= W'(r_e);
                r_m0  <= '0;
                r_m1  <= W'(1);
                r_idx <= 1'b0;
            end
            OP_RED_DONE: begin
                r_r1 <= w_rem;
            end
            OP_FIN1: begin
                r_mag <= (r_m0 >= r_lam) ? (r_m0 - r_lam) : r_m0;
            end
            OP_FIN2: begin
                r_d      <= DATA_W'(w_dfull);
                r_status <= ST_OK;
            end
            OP_SET_STATUS: begin
                r_d      <= '0;
                r_status <= i_cmd.status;
            end
            OP_PUBLISH: begin
                r_o_d  <= r_d;
                r_o_n  <= r_n;
                r_o_st <= r_status;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_stat.div_done   = w_done;
        o_stat.rem_zero   = (w_rem == '0);
        o_stat.x_lt2      = (r_x < PB'(2));
        o_stat.x_two      = (r_x == PB'(2));
        o_stat.x_even     = !r_x[0];
        o_stat.sq_gt_x    = (r_sq > SQ_W'(r_x));
        o_stat.r1_zero    = (r_r1 == '0);
        o_stat.r0_one     = (r_r0 == W'(1));
        o_stat.lam_gt_one = (r_lam > W'(1));
    end

    assign o_private_exponent = r_o_d;
    assign o_modulus          = r_o_n;
    assign o_status           = r_o_st;

endmodule

### rtl/core/rpe_ctrl.sv
// Controller: sequences primality tests, gcd, lcm and inverse, and owns the handshakes
`include "assert_macros.svh"

module rpe_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output rpe_pkg::t_cmd   o_cmd,
    input  rpe_pkg::t_dstat i_stat
);

    import rpe_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   r_which, n_which;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_G1;
            r_which     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_which     <= n_which;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_which      = r_which;
        o_cmd.op     = OP_NONE;
        o_cmd.status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_TP_INIT;
                end
            end
            S_TP_INIT: begin
                o_cmd.op = OP_TEST_P;
                n_which  = 1'b0;
                n_state  = S_T_CHK;
            end
            S_T_CHK: begin
                priority if (i_stat.x_lt2 || (i_stat.x_even && !i_stat.x_two)) begin
                    o_cmd.op     = OP_SET_STATUS;
                    o_cmd.status = r_which ? ST_Q_NOT_PRIME : ST_P_NOT_PRIME;
                    n_state      = S_FINISH;
                end else if (i_stat.x_two || i_stat.sq_gt_x) begin
                    if (!r_which) begin
                        o_cmd.op = OP_TEST_Q;
                        n_which  = 1'b1;
                    end else begin
                        n_state = S_G1_INIT;
                    end
                end else begin
                    o_cmd.op = OP_DIV_TRIAL;
                    n_state  = S_T_WAIT;
                end
            end
            S_T_WAIT: begin
                if (i_stat.div_done) begin
                    if (i_stat.rem_zero) begin
                        o_cmd.op     = OP_SET_STATUS;
                        o_cmd.status = r_which ? ST_Q_NOT_PRIME : ST_P_NOT_PRIME;
                        n_state      = S_FINISH;
                    end else begin
                        o_cmd.op = OP_TRIAL_NEXT;
                        n_state  = S_T_CHK;
                    end
                end
            end
            S_G1_INIT: begin
                o_cmd.op = OP_GCD1_INIT;
                n_phase  = PH_G1;
                n_state  = S_EUC_CHK;
            end
            S_EUC_CHK: begin
                if (i_stat.r1_zero) begin
                    unique case (r_phase)
                        PH_G1: n_state = S_LAM_DIV;
                        PH_G2: begin
                            priority if (!i_stat.r0_one) begin
                                o_cmd.op     = OP_SET_STATUS;
                                o_cmd.status = ST_NOT_COPRIME;
                                n_state      = S_FINISH;
                            end else if (i_stat.lam_gt_one) begin
                                n_state = S_INV_INIT;
                            end else begin
                                o_cmd.op     = OP_SET_STATUS;
                                o_cmd.status = ST_OK;
                                n_state      = S_FINISH;
                            end
                        end
                        PH_INV:  n_state = S_FIN1;
                        default: n_state = S_IDLE;
                    endcase
                end else begin
                    o_cmd.op = OP_DIV_EUC;
                    n_state  = S_EUC_WAIT;
                end
            end
            S_EUC_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_EUC_STEP;
                    n_state  = S_EUC_CHK;
                end
            end
            S_LAM_DIV: begin
                o_cmd.op = OP_DIV_LAM;
                n_state  = S_LAM_WAIT;
            end
            S_LAM_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_LAM_MUL;
                    n_state  = S_G2_INIT;
                end
            end
            S_G2_INIT: begin
                o_cmd.op = OP_GCD2_INIT;
                n_phase  = PH_G2;
                n_state  = S_EUC_CHK;
            end
            S_INV_INIT: begin
                o_cmd.op = OP_INV_INIT;
                n_state  = S_RED;
            end
            S_RED: begin
                o_cmd.op = OP_DIV_RED;
                n_state  = S_RED_WAIT;
            end
            S_RED_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_RED_DONE;
                    n_phase  = PH_INV;
                    n_state  = S_EUC_CHK;
                end
            end
            S_FIN1: begin
                o_cmd.op = OP_FIN1;
                n_state  = S_FIN2;
            end
            S_FIN2: begin
                o_cmd.op = OP_FIN2;
                n_state  = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op = OP_PUBLISH;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.op == OP_PUBLISH) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `RPE_ASSERT_IMP(a_publish_free, i_clk, i_rst_n, o_cmd.op == OP_PUBLISH, !r_out_valid || i_out_ready)
    `RPE_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `RPE_ASSERT_NEXT(a_publish_valid, i_clk, i_rst_n, o_cmd.op == OP_PUBLISH, o_out_valid)

endmodule

### rtl/core/rsa_private_exponent.sv
// Divisions (D trial divisions, E Euclid steps and other divisions) all run on one divider of width W,
// W = 32 at PRIME_BITS 16 (W = max(32, 2*PRIME_BITS)); the shared one-bit-per-cycle divider
// works them one after another, and one item is worked at a time.
// Throughput: the next item is taken once the previous one is done, while its result waits.
// Reset (i_rst_n low, synchronous) clears the controller and divider; no item is pending after.
module rsa_private_exponent #(
    parameter int PRIME_BITS = rpe_pkg::PRIME_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [rpe_pkg::IN_W-1:0]   i_prime_p,
    input  logic [rpe_pkg::IN_W-1:0]   i_prime_q,
    input  logic [rpe_pkg::DATA_W-1:0] i_public_exponent,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [rpe_pkg::DATA_W-1:0] o_private_exponent,
    output logic [rpe_pkg::DATA_W-1:0] o_modulus,
    output logic [1:0]                 o_status
);

    import rpe_pkg::*;

    t_cmd    w_cmd;
    t_dstat  w_stat;
    t_status w_status;

    rpe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    rpe_datapath #(
        .PRIME_BITS (PRIME_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_prime_p          (i_prime_p),
        .i_prime_q          (i_prime_q),
        .i_public_exponent  (i_public_exponent),
        .o_stat             (w_stat),
        .o_private_exponent (o_private_exponent),
        .o_modulus          (o_modulus),
        .o_status           (w_status)
    );

    assign o_status = w_status;

endmodule
